FILE: rtl/aes_rou_pkg.sv
// aes_rou_pkg: types, command codes and the forward s-box for the aes round unit
// no dependencies
package aes_rou_pkg;
	typedef logic [7:0] byte_t;
	typedef byte_t [15:0] state_t;

	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_ARK   = 3'd1,
		CMD_SUB   = 3'd2,
		CMD_SHIFT = 3'd3,
		CMD_MIX   = 3'd4
	} cmd_t;

	localparam int unsigned NUM_BYTES = 16;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_t xtime(byte_t b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the state sits at bits [127-8i -: 8] of the packed words
	function automatic state_t unpack(logic [63:0] hi, logic [63:0] lo);
		state_t s;
		for (int i = 0; i < 8; i++) begin
			s[i]     = hi[63-8*i -: 8];
			s[8 + i] = lo[63-8*i -: 8];
		end
		return s;
	endfunction
endpackage

FILE: rtl/aes_rou_if.sv
// aes_rou_in_if / aes_rou_out_if: valid/ready channels of the aes round unit
// depends on aes_rou_pkg
interface aes_rou_in_if;
	import aes_rou_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [63:0] data_hi;
	logic [63:0] data_lo;
	modport source (output valid, cmd, data_hi, data_lo, input ready);
	modport sink (input valid, cmd, data_hi, data_lo, output ready);
endinterface

interface aes_rou_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] state_hi;
	logic [63:0] state_lo;
	modport source (output valid, state_hi, state_lo, input ready);
	modport sink (input valid, state_hi, state_lo, output ready);
endinterface

FILE: rtl/aes_rou_xform.sv
// aes_rou_xform: combinational next-state for one command
// depends on aes_rou_pkg
module aes_rou_xform
	import aes_rou_pkg::*;
(
	input  logic [2:0] cmd,
	input  state_t     cur,
	input  state_t     data,
	output state_t     nxt
);
	state_t sub_s, shf_s, mix_s;

	always_comb begin
		byte_t a0, a1, a2, a3, all;
		for (int i = 0; i < 16; i++) sub_s[i] = SBOX[cur[i]];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				shf_s[r*4 + c] = cur[r*4 + ((c + r) % 4)];
		for (int c = 0; c < 4; c++) begin
			a0 = cur[c]; a1 = cur[4+c]; a2 = cur[8+c]; a3 = cur[12+c];
			all = a0 ^ a1 ^ a2 ^ a3;
			mix_s[c]    = a0 ^ all ^ xtime(a0 ^ a1);
			mix_s[4+c]  = a1 ^ all ^ xtime(a1 ^ a2);
			mix_s[8+c]  = a2 ^ all ^ xtime(a2 ^ a3);
			mix_s[12+c] = a3 ^ all ^ xtime(a3 ^ a0);
		end
	end

	always_comb begin
		unique case (cmd)
			CMD_LOAD:  nxt = data;
			CMD_ARK:   nxt = cur ^ data;
			CMD_SUB:   nxt = sub_s;
			CMD_SHIFT: nxt = shf_s;
			CMD_MIX:   nxt = mix_s;
			default:   nxt = cur;
		endcase
	end
endmodule

FILE: rtl/aes_round_operation_unit_top.sv
// aes round operation unit, top level: state register, transform and output register
// depends on aes_rou_pkg, aes_rou_if and aes_rou_xform
// the result is registered: valid in the cycle after the item is accepted
// throughput: one item per cycle unless the output stalls, via the combinational transform
// ready is high whenever the output register is empty or being drained this cycle
// reset: state clears to zero, output register empty
module aes_round_operation_unit_top
	import aes_rou_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	aes_rou_in_if.sink    in_ch,
	aes_rou_out_if.source out_ch
);
	state_t state_q, nxt;
	logic   out_valid_q;
	logic   acc;

	// output register doubles as the skid: free when empty or taken this cycle
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign acc = in_ch.valid && in_ch.ready;

	aes_rou_xform u_xform (
		.cmd  (in_ch.cmd),
		.cur  (state_q),
		.data (unpack(in_ch.data_hi, in_ch.data_lo)),
		.nxt  (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) state_q <= nxt;
			if (acc) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// the result is the held state itself, byte 0 in the top bits
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			out_ch.state_hi[63-8*i -: 8] = state_q[i];
			out_ch.state_lo[63-8*i -: 8] = state_q[8+i];
		end
	end
	assign out_ch.valid = out_valid_q;

	// a stalled result must not change under the consumer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(state_q))
		else $error("state changed while result stalled");
	// accepting an item always yields a result next cycle
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_ch.valid)
		else $error("accepted item produced no result");
	// state only moves on an accepted item
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(state_q))
		else $error("state changed without an item");
endmodule
